### hdl/wtok_pkg.sv
// shared constants, types and character helpers for the word tokenizer
// used by the front end, queue, back end and top level of the block; depends on nothing
`default_nettype none
package wtok_pkg;

   localparam int MAX_WORD = 32;
   localparam int BANKS    = 2;
   localparam int ADDR_W   = $clog2(MAX_WORD);
   localparam int LEN_W    = $clog2(MAX_WORD + 1);
   localparam int MEM_AW   = ADDR_W + 1;
   localparam int MEM_DEPTH = BANKS * (2 ** ADDR_W);
   localparam int CNT_W    = 7;
   localparam int WN_W     = 16;
   localparam int POS_W    = 6;

   localparam logic [CNT_W-1:0] CNT_MAX  = 7'd127;
   localparam logic [WN_W-1:0]  WN_MAX   = 16'hFFFF;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_APOS   = 8'h27;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFS  = 8'h20;
   localparam logic [7:0] CH_A      = 8'h61;
   localparam logic [7:0] CH_C      = 8'h63;
   localparam logic [7:0] CH_E      = 8'h65;
   localparam logic [7:0] CH_I      = 8'h69;
   localparam logic [7:0] CH_O      = 8'h6F;
   localparam logic [7:0] L1_E_ACUTE_UP = 8'hC9;
   localparam logic [7:0] L1_E_GRAVE    = 8'hE8;
   localparam logic [7:0] L1_E_CIRC     = 8'hEA;
   localparam logic [7:0] L1_C_CEDIL    = 8'hE7;
   localparam logic [7:0] L1_I_CIRC     = 8'hEE;
   localparam logic [7:0] L1_O_CIRC     = 8'hF4;
   localparam logic [7:0] L1_A_GRAVE    = 8'hE0;
   localparam logic [7:0] L1_A_CIRC     = 8'hE2;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic             trunc;
      logic [WN_W-1:0]  word_num;
   } desc_type;

   typedef struct packed {
      logic              en;
      logic [MEM_AW-1:0] addr;
      logic [7:0]        data;
   } mem_wr_type;

   typedef struct packed {
      logic     valid;
      logic     bank;
      desc_type desc;
   } push_type;

   typedef struct packed {
      logic              en;
      logic              bank;
      logic [ADDR_W-1:0] pos;
      logic              pop;
   } rd_req_type;

   function automatic logic is_separator(input logic [7:0] b);
      return b == CH_SPACE || b == CH_SLASH || b == CH_COMMA || b == CH_SEMI ||
             b == CH_DOT || b == CH_COLON || b == CH_BANG || b == CH_QMARK ||
             b == CH_LPAREN || b == CH_RPAREN || b == CH_LF || b == CH_DQUOTE;
   endfunction

   function automatic logic [7:0] fold_letter(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= CH_UPPER_A && b <= CH_UPPER_Z) r = b + CASE_OFS;
      else if (b == L1_E_ACUTE_UP || (b >= L1_E_GRAVE && b <= L1_E_CIRC)) r = CH_E;
      else if (b == L1_C_CEDIL) r = CH_C;
      else if (b == L1_I_CIRC) r = CH_I;
      else if (b == L1_O_CIRC) r = CH_O;
      else if (b == L1_A_GRAVE || b == L1_A_CIRC) r = CH_A;
      return r;
   endfunction

endpackage
`default_nettype wire

### hdl/wtok_front.sv
// front end: accepts text bytes, strips markup, folds letters into the word buffer
// and pushes a descriptor per accepted word; depends on wtok_pkg
`default_nettype none
module wtok_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [7:0]                   req_tdata,
   input  wire logic                         req_tlast,
   input  wire logic                         csr_valid,
   input  wire logic [wtok_pkg::CNT_W-1:0]   csr_data,
   input  wire logic [wtok_pkg::BANKS-1:0]   busy,
   output wtok_pkg::mem_wr_type              mem_wr,
   output wtok_pkg::push_type                push
);

   logic                        tag_ff, tag_in;
   logic [wtok_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        ovf_ff, ovf_in;
   logic [wtok_pkg::WN_W-1:0]   wc_ff, wc_in;
   logic                        wb_ff, wb_in;
   logic [wtok_pkg::CNT_W-1:0]  min_ff, min_in;

   logic                        accept, is_lt, is_sep, is_apos, letter, apos, close, emit, room;
   logic [wtok_pkg::CNT_W-1:0]  cnt_a, cnt_c;
   logic                        ovf_a, ovf_c;

   always_comb begin
      req_tready = !busy[wb_ff];
      accept     = req_tvalid && req_tready;
      is_lt      = req_tdata == wtok_pkg::CH_LT;
      is_sep     = wtok_pkg::is_separator(req_tdata);
      is_apos    = req_tdata == wtok_pkg::CH_APOS;
      letter     = !tag_ff && !is_lt && !is_sep && !is_apos;
      apos       = !tag_ff && !is_lt && !is_sep && is_apos;
      room       = cnt_ff < wtok_pkg::CNT_W'(wtok_pkg::MAX_WORD);

      cnt_a = cnt_ff;
      ovf_a = ovf_ff;
      if (letter) begin
         if (cnt_ff != wtok_pkg::CNT_MAX) cnt_a = cnt_ff + 1'b1;
         if (!room) ovf_a = 1'b1;
      end
      cnt_c = apos ? '0 : cnt_a;
      ovf_c = apos ? 1'b0 : ovf_a;

      close = (!tag_ff && !is_lt && is_sep) || req_tlast;
      emit  = accept && close && cnt_c != '0 && cnt_c >= min_ff;

      mem_wr.en   = accept && letter && room;
      mem_wr.addr = {wb_ff, cnt_ff[wtok_pkg::ADDR_W-1:0]};
      mem_wr.data = wtok_pkg::fold_letter(req_tdata);

      push.valid         = emit;
      push.bank          = wb_ff;
      push.desc.len      = (cnt_c < wtok_pkg::CNT_W'(wtok_pkg::MAX_WORD)) ?
                           wtok_pkg::LEN_W'(cnt_c) : wtok_pkg::LEN_W'(wtok_pkg::MAX_WORD);
      push.desc.trunc    = ovf_c;
      push.desc.word_num = wc_ff;

      tag_in = tag_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      wc_in  = wc_ff;
      wb_in  = wb_ff;
      if (accept) begin
         if (req_tlast) tag_in = 1'b0;
         else if (tag_ff) tag_in = req_tdata != wtok_pkg::CH_GT;
         else tag_in = is_lt;
         cnt_in = (close || apos) ? '0 : cnt_a;
         ovf_in = (close || apos) ? 1'b0 : ovf_a;
         if (req_tlast) wc_in = '0;
         else if (emit && wc_ff != wtok_pkg::WN_MAX) wc_in = wc_ff + 1'b1;
         if (emit) wb_in = !wb_ff;
      end
      min_in = csr_valid ? csr_data : min_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= 1'b0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         wc_ff  <= '0;
         wb_ff  <= 1'b0;
         min_ff <= wtok_pkg::CNT_W'(4);
      end else begin
         tag_ff <= tag_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
         wc_ff  <= wc_in;
         wb_ff  <= wb_in;
         min_ff <= min_in;
      end
   end

endmodule
`default_nettype wire

### hdl/wtok_queue.sv
// two-bank word buffer with one descriptor slot per bank, filled by the front
// and drained by the back; depends on wtok_pkg
`default_nettype none
module wtok_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire wtok_pkg::mem_wr_type        mem_wr,
   input  wire wtok_pkg::push_type          push,
   input  wire wtok_pkg::rd_req_type        rd_req,
   output logic [wtok_pkg::BANKS-1:0]       busy,
   output wtok_pkg::desc_type               desc_sel,
   output logic [7:0]                       rd_data
);

   logic [7:0]                      mem [wtok_pkg::MEM_DEPTH];
   logic [7:0]                      rd_data_ff;
   wtok_pkg::desc_type              desc_ff [wtok_pkg::BANKS];
   logic [wtok_pkg::BANKS-1:0]      busy_ff, busy_in;

   always_comb begin
      busy_in = busy_ff;
      if (push.valid) busy_in[push.bank] = 1'b1;
      if (rd_req.pop) busy_in[rd_req.bank] = 1'b0;
      busy     = busy_ff;
      desc_sel = desc_ff[rd_req.bank];
      rd_data  = rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_wr.en) mem[mem_wr.addr] <= mem_wr.data;
      if (rd_req.en) rd_data_ff <= mem[{rd_req.bank, rd_req.pos}];
   end

   always_ff @(posedge clock) begin
      if (push.valid) desc_ff[push.bank] <= push.desc;
   end

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= '0;
      else busy_ff <= busy_in;
   end

endmodule
`default_nettype wire

### hdl/wtok_back.sv
// back end: walks the filled banks in order and emits one character beat
// per cycle while rsp_tready is high, through the output register; depends on wtok_pkg
`default_nettype none
module wtok_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [wtok_pkg::BANKS-1:0]   busy,
   input  wire wtok_pkg::desc_type           desc_sel,
   output wtok_pkg::rd_req_type              rd_req,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [wtok_pkg::WN_W-1:0]         word_num,
   output logic [wtok_pkg::POS_W-1:0]        char_pos,
   output logic                              rsp_tlast,
   output logic                              trunc
);

   logic                         rb_ff, rb_in;
   logic [wtok_pkg::ADDR_W-1:0]  pos_ff, pos_in;
   logic                         valid_ff, valid_in;
   logic [wtok_pkg::WN_W-1:0]    wn_ff;
   logic [wtok_pkg::POS_W-1:0]   cpos_ff;
   logic                         last_ff, trunc_ff;
   logic                         load, fetch, is_last;

   always_comb begin
      load    = !valid_ff || rsp_tready;
      fetch   = load && busy[rb_ff];
      is_last = (wtok_pkg::LEN_W'(pos_ff) + 1'b1) == desc_sel.len;

      rd_req.en   = fetch;
      rd_req.bank = rb_ff;
      rd_req.pos  = pos_ff;
      rd_req.pop  = fetch && is_last;

      valid_in = load ? fetch : valid_ff;
      rb_in    = rb_ff;
      pos_in   = pos_ff;
      if (fetch) begin
         if (is_last) begin
            pos_in = '0;
            rb_in  = !rb_ff;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end

      rsp_tvalid = valid_ff;
      word_num   = wn_ff;
      char_pos   = cpos_ff;
      rsp_tlast  = last_ff;
      trunc      = trunc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rb_ff    <= 1'b0;
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         rb_ff    <= rb_in;
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fetch) begin
         wn_ff    <= desc_sel.word_num;
         cpos_ff  <= wtok_pkg::POS_W'(pos_ff);
         last_ff  <= is_last;
         trunc_ff <= desc_sel.trunc;
      end
   end

endmodule
`default_nettype wire

### hdl/text_word_tokenizer_top.sv
// top level of the word tokenizer: front end, two-bank word queue and back end
// depends on wtok_pkg, wtok_front, wtok_queue and wtok_back
//
// Takes one text byte per cycle and, while rsp_tready is high, emits one
// character beat per cycle. A byte is held off only while the buffer bank
// that the current word fills is still being read out, so with two banks
// the stream keeps pace as long as each word takes at least as many input
// bytes as the word before it emits characters. A word's first character
// appears once its bank is marked busy and is read into the output register.
`default_nettype none
module text_word_tokenizer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // in_byte
   input  wire logic        req_tlast,   // end_of_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // out_char, word_number, char_position, zero pad
   output logic             rsp_tlast,   // last_char
   output logic [0:0]       rsp_tuser,   // truncated
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [6:0]  csr_data     // min_letters
);

   wtok_pkg::mem_wr_type            mem_wr;
   wtok_pkg::push_type              push;
   wtok_pkg::rd_req_type            rd_req;
   wtok_pkg::desc_type              desc_sel;
   logic [wtok_pkg::BANKS-1:0]      busy;
   logic [7:0]                      rd_data;
   logic [wtok_pkg::WN_W-1:0]       word_num;
   logic [wtok_pkg::POS_W-1:0]      char_pos;
   logic                            trunc;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {2'b00, char_pos, word_num, rd_data};
   assign rsp_tuser = trunc;

   wtok_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .busy       (busy),
      .mem_wr     (mem_wr),
      .push       (push)
   );

   wtok_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .mem_wr   (mem_wr),
      .push     (push),
      .rd_req   (rd_req),
      .busy     (busy),
      .desc_sel (desc_sel),
      .rd_data  (rd_data)
   );

   wtok_back u_back (
      .clock      (clock),
      .reset      (reset),
      .busy       (busy),
      .desc_sel   (desc_sel),
      .rd_req     (rd_req),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .word_num   (word_num),
      .char_pos   (char_pos),
      .rsp_tlast  (rsp_tlast),
      .trunc      (trunc)
   );

endmodule
`default_nettype wire

### hdl/wtok_checker.sv
// port-level checks for the word tokenizer and the bind that attaches them
// depends on text_word_tokenizer_top
`default_nettype none
module wtok_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic        rsp_tlast,
   input  wire logic [0:0]  rsp_tuser
);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // inside a word the position steps by one
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         !rsp_tvalid || rsp_tdata[29:24] == $past(rsp_tdata[29:24]) + 6'd1)
      else $error("char position skipped");

   // word number and truncation flag stay fixed across a word
   a_word_fixed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         !rsp_tvalid || ($stable(rsp_tdata[23:8]) && $stable(rsp_tuser)))
      else $error("word fields changed inside a word");

endmodule

bind text_word_tokenizer_top wtok_checker u_wtok_checker (.*);
`default_nettype wire
